// File: hw/rtl/psil_pkg.sv
// Shared constants for the prime sieve index lookup block.
// Field widths, function codes and status codes; no dependencies.
package psil_pkg;

    // Fixed field widths
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 13;
    localparam int TOTAL_W  = 14;

    // Request function codes
    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

endpackage

// File: hw/rtl/psil_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No package dependency; used for the composite map and the prime list.
module psil_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/prime_sieve_index_lookup.sv
// Prime sieve with prime index lookup: one request in, one result out, one at a time.
// Queries that are not built or out of range go straight to the result; others read the map,
// and a prime then binary-searches the prime list in at most log2(count)+1 steps, so <= 14.
// Build: clear the map over 0..top, test each candidate up to sqrt(top), mark the multiples
// of each sieving prime, then collect the primes in ascending order into the list.
// Ready returns as the result is posted; reset clears control, count, built and valid flags, sets top.
module prime_sieve_index_lookup #(
    parameter int NUMBER_RANGE = 65536,
    parameter int PRIME_SLOTS  = 8192
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [psil_pkg::VALUE_W-1:0]    i_cfg_data,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [psil_pkg::VALUE_W-1:0]    i_query_value,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [psil_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_is_prime,
    output logic [psil_pkg::POS_W-1:0]      o_prime_position,
    output logic [psil_pkg::TOTAL_W-1:0]    o_prime_total
);
    import psil_pkg::*;

    localparam int MAP_DEPTH = (NUMBER_RANGE > 65536) ? 65536 : NUMBER_RANGE;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int SW        = $clog2(PRIME_SLOTS);
    localparam int CW        = $clog2(PRIME_SLOTS + 1);
    localparam int NW        = VALUE_W + 1;

    localparam logic [VALUE_W-1:0] MAP_MAX = VALUE_W'(MAP_DEPTH - 1);
    localparam logic [CW-1:0]      SLOTS_C = CW'(PRIME_SLOTS);

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLR     = 4'd1;
    localparam logic [3:0] S_SV_RD   = 4'd2;
    localparam logic [3:0] S_SV_CHK  = 4'd3;
    localparam logic [3:0] S_SV_MARK = 4'd4;
    localparam logic [3:0] S_CL_RD   = 4'd5;
    localparam logic [3:0] S_CL_CHK  = 4'd6;
    localparam logic [3:0] S_Q_MAP   = 4'd7;
    localparam logic [3:0] S_BS_RD   = 4'd8;
    localparam logic [3:0] S_BS_CHK  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [VALUE_W-1:0]  r_sieve_top;
    logic [VALUE_W-1:0]  r_top, n_top;
    logic [VALUE_W-1:0]  r_built_top, n_built_top;
    logic                r_built, n_built;
    logic [CW-1:0]       r_count, n_count;
    logic [NW-1:0]       r_p, n_p;
    logic [NW-1:0]       r_sq, n_sq;
    logic [NW-1:0]       r_m, n_m;
    logic [CW-1:0]       r_k, n_k;
    logic [VALUE_W-1:0]  r_x, n_x;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [SW-1:0]       r_mid, n_mid;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_res_prime, n_res_prime;
    logic [SW-1:0]       r_res_pos, n_res_pos;

    logic                r_o_valid, n_o_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic                r_o_prime, n_o_prime;
    logic [POS_W-1:0]    r_o_pos, n_o_pos;
    logic [TOTAL_W-1:0]  r_o_total, n_o_total;

    // Memory ports
    logic                map_we;
    logic [NW-1:0]       map_waddr_n;
    logic                map_wdata;
    logic [NW-1:0]       map_raddr_n;
    logic                map_rdata;
    logic                list_we;
    logic [VALUE_W-1:0]  list_rdata;
    logic [SW-1:0]       list_raddr;

    // Shared adder results
    logic [NW-1:0]       sq_next;
    logic [CW:0]         mid_sum;
    logic [SW-1:0]       mid_calc;
    logic [VALUE_W-1:0]  build_top;
    logic [SW+POS_W-1:0] pos_ext;
    logic [CW+TOTAL_W-1:0] total_ext;
    logic                accept;
    logic                out_free;

    assign accept    = i_valid && o_ready;
    assign out_free  = !r_o_valid || i_ready;
    assign sq_next   = r_sq + {r_p[NW-2:0], 1'b0} + NW'(1);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_calc  = mid_sum[SW:1];
    assign build_top = (r_sieve_top > MAP_MAX) ? MAP_MAX : r_sieve_top;
    assign pos_ext   = {{POS_W{1'b0}}, r_res_pos};
    assign total_ext = {{TOTAL_W{1'b0}}, r_count};

    psil_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr_n[AW-1:0]),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr_n[AW-1:0]),
        .o_rdata (map_rdata)
    );

    psil_ram #(.WIDTH(VALUE_W), .DEPTH(PRIME_SLOTS)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (r_k[SW-1:0]),
        .i_wdata (r_p[VALUE_W-1:0]),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    // Sequencer: sieve build and binary search share the counters and adders
    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_built_top  = r_built_top;
        n_built      = r_built;
        n_count      = r_count;
        n_p          = r_p;
        n_sq         = r_sq;
        n_m          = r_m;
        n_k          = r_k;
        n_x          = r_x;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_res_status = r_res_status;
        n_res_prime  = r_res_prime;
        n_res_pos    = r_res_pos;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_prime    = r_o_prime;
        n_o_pos      = r_o_pos;
        n_o_total    = r_o_total;
        map_we       = 1'b0;
        map_waddr_n  = r_p;
        map_wdata    = 1'b1;
        map_raddr_n  = r_p;
        list_we      = 1'b0;
        list_raddr   = mid_calc;

        unique case (r_state)
            S_IDLE: begin
                map_raddr_n = {1'b0, i_query_value};
                if (accept) begin
                    n_res_status = ST_OK;
                    n_res_prime  = 1'b0;
                    n_res_pos    = '0;
                    n_x          = i_query_value;
                    if (i_func == FUNC_BUILD) begin
                        n_top   = build_top;
                        n_p     = '0;
                        n_state = S_CLR;
                    end else if (!r_built) begin
                        n_res_status = ST_NOT_BUILT;
                        n_state      = S_DONE;
                    end else if (i_query_value < VALUE_W'(2) ||
                                 i_query_value > r_built_top) begin
                        n_res_status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_Q_MAP;
                    end
                end
            end
            // Clear the map over 0..top, marking 0 and 1 as non-prime
            S_CLR: begin
                map_we    = 1'b1;
                map_wdata = (r_p < NW'(2));
                if (r_p == {1'b0, r_top}) begin
                    n_p     = NW'(2);
                    n_sq    = NW'(4);
                    n_state = S_SV_RD;
                end else begin
                    n_p = r_p + NW'(1);
                end
            end
            // Read the candidate sieving number while its square fits
            S_SV_RD: begin
                if (r_sq > {1'b0, r_top}) begin
                    n_p     = NW'(2);
                    n_k     = '0;
                    n_state = S_CL_RD;
                end else begin
                    n_state = S_SV_CHK;
                end
            end
            S_SV_CHK: begin
                if (map_rdata) begin
                    n_sq    = sq_next;
                    n_p     = r_p + NW'(1);
                    n_state = S_SV_RD;
                end else begin
                    n_m     = r_sq;
                    n_state = S_SV_MARK;
                end
            end
            // Mark multiples from p*p upward
            S_SV_MARK: begin
                map_waddr_n = r_m;
                if (r_m > {1'b0, r_top}) begin
                    n_sq    = sq_next;
                    n_p     = r_p + NW'(1);
                    n_state = S_SV_RD;
                end else begin
                    map_we = 1'b1;
                    n_m    = r_m + r_p;
                end
            end
            // Collect primes in ascending order until top or the list is full
            S_CL_RD: begin
                if (r_p > {1'b0, r_top} || r_k == SLOTS_C) begin
                    n_count     = r_k;
                    n_built_top = r_top;
                    n_built     = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_CL_CHK;
                end
            end
            S_CL_CHK: begin
                if (!map_rdata) begin
                    list_we = 1'b1;
                    n_k     = r_k + CW'(1);
                end
                n_p     = r_p + NW'(1);
                n_state = S_CL_RD;
            end
            // Composite check, then set up the search window
            S_Q_MAP: begin
                if (map_rdata) begin
                    n_state = S_DONE;
                end else begin
                    n_res_prime = 1'b1;
                    n_lo        = '0;
                    n_hi        = r_count;
                    n_state     = S_BS_RD;
                end
            end
            S_BS_RD: begin
                if (r_lo >= r_hi) begin
                    n_state = S_DONE;
                end else begin
                    n_mid   = mid_calc;
                    n_state = S_BS_CHK;
                end
            end
            S_BS_CHK: begin
                if (r_x < list_rdata) begin
                    n_hi    = CW'(r_mid);
                    n_state = S_BS_RD;
                end else if (r_x > list_rdata) begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = S_BS_RD;
                end else begin
                    n_res_pos = r_mid;
                    n_state   = S_DONE;
                end
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_prime  = r_res_prime;
                    n_o_pos    = pos_ext[POS_W-1:0];
                    n_o_total  = total_ext[TOTAL_W-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sieve_top <= 16'hFFFF;
            r_built     <= 1'b0;
            r_count     <= '0;
            r_built_top <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_count     <= n_count;
            r_built_top <= n_built_top;
            r_o_valid   <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_sieve_top <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_p          <= n_p;
        r_sq         <= n_sq;
        r_m          <= n_m;
        r_k          <= n_k;
        r_x          <= n_x;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_res_status <= n_res_status;
        r_res_prime  <= n_res_prime;
        r_res_pos    <= n_res_pos;
        r_o_status   <= n_o_status;
        r_o_prime    <= n_o_prime;
        r_o_pos      <= n_o_pos;
        r_o_total    <= n_o_total;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_is_prime       = r_o_prime;
    assign o_prime_position = r_o_pos;
    assign o_prime_total    = r_o_total;

endmodule

// File: hw/rtl/psil_checker.sv
// Port-level checks for the prime sieve index lookup block.
// Depends on psil_pkg; bound to the top level at the end of this file.
module psil_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [psil_pkg::STATUS_W-1:0] o_status,
    input logic                          o_is_prime,
    input logic [psil_pkg::POS_W-1:0]    o_prime_position,
    input logic [psil_pkg::TOTAL_W-1:0]  o_prime_total
);
    import psil_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // One request at a time: busy right after accepting one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while a request is in progress");

    // Stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_is_prime)
            && $stable(o_prime_position) && $stable(o_prime_total)))
        else $error("stalled result changed");

    // Not-built answers carry nothing else
    a_not_built_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOT_BUILT) |->
            (!o_is_prime && o_prime_position == '0 && o_prime_total == '0))
        else $error("not-built result carries data");

    // A prime answer is always an ok answer
    a_prime_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_is_prime || o_prime_position != '0)) |->
            (o_status == ST_OK && o_status != ST_UNUSED))
        else $error("prime flag or position with bad status");

endmodule

bind prime_sieve_index_lookup psil_checker u_psil_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_is_prime       (o_is_prime),
    .o_prime_position (o_prime_position),
    .o_prime_total    (o_prime_total)
);

// File: sim/tb_top.sv
// Testbench for prime_sieve_index_lookup: directed table, then random build/query phases.
// Depends on psil_pkg and the RTL top; checks every result against the table or its own sieve predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psil_pkg::*;

    localparam int MAP_DEPTH    = 65536;
    localparam int LIST_DEPTH   = 8192;
    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_prime;
        logic [POS_W-1:0]    pos;
        logic [TOTAL_W-1:0]  total;
    } t_answer;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               func;
        logic [VALUE_W-1:0] value;
        logic               typed;
        t_answer            want;
    } t_step;

    localparam t_answer PREDICTED = '0;
    localparam int      N_DIRECTED = 27;

    // Directed table; config rows carry the new sieve top in value
    localparam t_step DIRECTED [N_DIRECTED] = '{
        '{ROW_REQUEST, FUNC_QUERY, 16'd100,   1'b1, '{ST_NOT_BUILT, 1'b0, 13'd0,    14'd0}},
        '{ROW_REQUEST, FUNC_QUERY, 16'hFFFF,  1'b1, '{ST_NOT_BUILT, 1'b0, 13'd0,    14'd0}},
        '{ROW_REQUEST, FUNC_BUILD, 16'd0,     1'b1, '{ST_OK,        1'b0, 13'd0,    14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd65521, 1'b1, '{ST_OK,        1'b1, 13'd6541, 14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd2,     1'b1, '{ST_OK,        1'b1, 13'd0,    14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd3,     1'b1, '{ST_OK,        1'b1, 13'd1,    14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'hFFFF,  1'b1, '{ST_OK,        1'b0, 13'd0,    14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd0,     1'b1, '{ST_RANGE,     1'b0, 13'd0,    14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd1,     1'b1, '{ST_RANGE,     1'b0, 13'd0,    14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd4,     1'b1, '{ST_OK,        1'b0, 13'd0,    14'd6542}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd32749, 1'b0, PREDICTED},
        '{ROW_CONFIG,  FUNC_BUILD, 16'd2,     1'b0, PREDICTED},
        '{ROW_REQUEST, FUNC_BUILD, 16'hFFFF,  1'b1, '{ST_OK,        1'b0, 13'd0,    14'd1}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd2,     1'b1, '{ST_OK,        1'b1, 13'd0,    14'd1}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd3,     1'b1, '{ST_RANGE,     1'b0, 13'd0,    14'd1}},
        '{ROW_CONFIG,  FUNC_BUILD, 16'hFFFF,  1'b0, PREDICTED},
        '{ROW_REQUEST, FUNC_QUERY, 16'd40000, 1'b1, '{ST_RANGE,     1'b0, 13'd0,    14'd1}},
        '{ROW_CONFIG,  FUNC_BUILD, 16'd1,     1'b0, PREDICTED},
        '{ROW_REQUEST, FUNC_BUILD, 16'd0,     1'b1, '{ST_OK,        1'b0, 13'd0,    14'd0}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd2,     1'b1, '{ST_RANGE,     1'b0, 13'd0,    14'd0}},
        '{ROW_CONFIG,  FUNC_BUILD, 16'd0,     1'b0, PREDICTED},
        '{ROW_REQUEST, FUNC_BUILD, 16'd0,     1'b1, '{ST_OK,        1'b0, 13'd0,    14'd0}},
        '{ROW_CONFIG,  FUNC_BUILD, 16'd100,   1'b0, PREDICTED},
        '{ROW_REQUEST, FUNC_BUILD, 16'd0,     1'b1, '{ST_OK,        1'b0, 13'd0,    14'd25}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd97,    1'b1, '{ST_OK,        1'b1, 13'd24,   14'd25}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd100,   1'b1, '{ST_OK,        1'b0, 13'd0,    14'd25}},
        '{ROW_REQUEST, FUNC_QUERY, 16'd101,   1'b1, '{ST_RANGE,     1'b0, 13'd0,    14'd25}}
    };

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [VALUE_W-1:0] i_cfg_data    = '0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic               i_func        = FUNC_BUILD;
    logic [VALUE_W-1:0] i_query_value = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic               o_is_prime;
    logic [POS_W-1:0]   o_prime_position;
    logic [TOTAL_W-1:0] o_prime_total;

    // Predictor state: sieve bitmap, prime list, rank of each listed prime
    bit          composite  [MAP_DEPTH];
    logic [15:0] prime_tab  [LIST_DEPTH];
    int unsigned prime_rank [MAP_DEPTH];
    int unsigned prime_cnt  = 0;
    int unsigned built_top  = 0;
    int unsigned cfg_top    = 65535;
    bit          built      = 1'b0;

    t_answer     pending_answers [$];
    int          mismatches   = 0;
    int          answers_seen = 0;
    int          cycles       = 0;
    bit          calm         = 1'b0;

    prime_sieve_index_lookup #(
        .NUMBER_RANGE (MAP_DEPTH),
        .PRIME_SLOTS  (LIST_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_query_value    (i_query_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_is_prime       (o_is_prime),
        .o_prime_position (o_prime_position),
        .o_prime_total    (o_prime_total)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Work out the answer to one accepted request and advance the sieve state
    function automatic t_answer sieve_answer(input logic func,
                                             input logic [VALUE_W-1:0] value);
        t_answer     ans;
        int unsigned top;
        int unsigned p;
        int unsigned m;
        int unsigned k;
        ans = '0;
        ans.status = ST_OK;
        if (func == FUNC_BUILD) begin
            top = cfg_top;
            if (top > MAP_DEPTH - 1) begin
                top = MAP_DEPTH - 1;
            end
            for (int i = 0; i < MAP_DEPTH; i++) begin
                composite[i]  = 1'b0;
                prime_rank[i] = 0;
            end
            composite[0] = 1'b1;
            composite[1] = 1'b1;
            for (p = 2; p * p <= top; p++) begin
                if (!composite[p]) begin
                    for (m = p * p; m <= top; m += p) begin
                        composite[m] = 1'b1;
                    end
                end
            end
            // Collect primes in order until the list is full
            k = 0;
            for (p = 2; p <= top && k < LIST_DEPTH; p++) begin
                if (!composite[p]) begin
                    prime_tab[k]  = p[15:0];
                    prime_rank[p] = k;
                    k++;
                end
            end
            prime_cnt = k;
            built_top = top;
            built     = 1'b1;
        end else if (!built) begin
            ans.status = ST_NOT_BUILT;
        end else if (value < 2 || value > built_top) begin
            ans.status = ST_RANGE;
        end else if (!composite[value]) begin
            ans.is_prime = 1'b1;
            ans.pos      = prime_rank[value][POS_W-1:0];
        end
        ans.total = built ? prime_cnt[TOTAL_W-1:0] : '0;
        return ans;
    endfunction

    // Offer one request, hold it until accepted, then queue its answer
    task automatic offer(input logic func, input logic [VALUE_W-1:0] value,
                         input logic typed, input t_answer want);
        t_answer ans;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_query_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        ans = sieve_answer(func, value);
        pending_answers.push_back(typed ? want : ans);
    endtask

    // Drop valid and wait until every queued answer has come back
    task automatic drain_answers();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_top(input logic [VALUE_W-1:0] top);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= top;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_top = 32'(top);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result with the oldest queued answer
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            answers_seen <= answers_seen + 1;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result: status %0d prime %0d pos %0d total %0d",
                         $time, o_status, o_is_prime, o_prime_position, o_prime_total);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                check_field("status", want.status, o_status);
                check_field("is_prime", want.is_prime, o_is_prime);
                check_field("prime_position", want.pos, o_prime_position);
                check_field("prime_total", want.total, o_prime_total);
            end
        end
    end

    // Result side: random stalls, one long hold-off to back up the request side
    initial begin : result_ready
        bit held_off;
        held_off = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held_off && answers_seen >= 60 && i_valid) begin
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Request side: reset, directed table, random phases, final drain
    initial begin : stimulus
        int          random_sent;
        int          n_queries;
        logic [15:0] top;
        logic [15:0] value;
        random_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CONFIG) begin
                drain_answers();
                write_top(DIRECTED[i].value);
            end else begin
                offer(DIRECTED[i].func, DIRECTED[i].value, DIRECTED[i].typed,
                      DIRECTED[i].want);
            end
        end

        // Each phase: new top, usually a build, then a run of queries
        while (random_sent < RANDOM_ITEMS) begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            drain_answers();
            case ($urandom_range(0, 9))
                0: begin
                    top = 16'($urandom_range(0, 3));
                end
                1, 2: begin
                    top = 16'($urandom_range(1500, 4000));
                end
                default: begin
                    top = 16'($urandom_range(4, 1200));
                end
            endcase
            write_top(top);
            // Skip the build now and then so queries see a stale top
            if ($urandom_range(0, 6) != 0) begin
                offer(FUNC_BUILD, 16'($urandom()), 1'b0, PREDICTED);
                random_sent++;
            end
            n_queries = $urandom_range(15, 45);
            repeat (n_queries) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        if (prime_cnt > 0) begin
                            value = prime_tab[$urandom_range(0, prime_cnt - 1)];
                        end else begin
                            value = 16'($urandom_range(0, 3));
                        end
                    end
                    4, 5, 6: begin
                        value = 16'($urandom_range(0, built_top + 2));
                    end
                    7: begin
                        value = 16'(built_top + $urandom_range(0, 1));
                    end
                    default: begin
                        value = 16'($urandom());
                    end
                endcase
                offer(FUNC_QUERY, value, 1'b0, PREDICTED);
                random_sent++;
            end
        end

        drain_answers();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
